FILE: design/trial_division_prime_test_macros.svh
// ----------------------------------------------------------------------------
// Trial division prime test assertion macros
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef TRIAL_DIVISION_PRIME_TEST_MACROS_SVH
`define TRIAL_DIVISION_PRIME_TEST_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define TDPT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tdpt: assertion failed");

// next-cycle implication
`define TDPT_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tdpt: assertion failed");

`else

`define TDPT_ASSERT_IMP(label, clk, rst, ante, cons)
`define TDPT_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: design/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// Trial division prime test package
// Widths, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package tdpt_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DATA_WIDTH);
  localparam int SQ_W       = DATA_WIDTH + 2;
  localparam int FIRST_DIV  = 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_TEST,
    S_POST
  } state_t;

  typedef struct packed {
    logic load;       // capture new number, reset trial divisor
    logic start_div;  // clear remainder, start serial division
    logic div_step;   // one restoring division bit
    logic advance;    // next trial divisor and its square
    logic decide;     // latch verdict
    logic verdict;
    logic post;       // move verdict into the output register
  } cmd_t;

  typedef struct packed {
    logic trivial;    // negative, zero or one
    logic sq_gt_n;    // divisor squared exceeds the number
    logic div_last;   // final division bit this cycle
    logic rem_zero;
  } stat_t;

endpackage

FILE: design/tdpt_num_if.sv
// ----------------------------------------------------------------------------
// Number channel
// Valid/ready channel carrying the signed value under test.
// ----------------------------------------------------------------------------
interface tdpt_num_if
  import tdpt_pkg::*;
;
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

FILE: design/tdpt_res_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the prime verdict.
// ----------------------------------------------------------------------------
interface tdpt_res_if;
  logic valid;
  logic ready;
  logic is_prime;

  modport source (output valid, output is_prime, input ready);
  modport sink   (input valid, input is_prime, output ready);
endinterface

FILE: design/trial_division_prime_test.sv
// ----------------------------------------------------------------------------
// Trial division prime test
// Numbers below 4 or negative are decided by the bound check without division;
// otherwise each trial divisor runs a serial division, one remainder bit per cycle,
// until a zero remainder marks a composite or the divisor square exceeds the number.
// Throughput: one number in flight; the next is taken the cycle after its result
// is posted, so an output stall also delays the next input.
// Synchronous reset clears only the control state.
// ----------------------------------------------------------------------------
`include "trial_division_prime_test_macros.svh"

module trial_division_prime_test
  import tdpt_pkg::*;
(
  input logic              clk,
  input logic              rst,
  tdpt_num_if.sink         req,
  tdpt_res_if.source       rsp
);

  cmd_t  cmd;
  stat_t stat;

  tdpt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tdpt_datapath u_dp (
    .clk      (clk),
    .number   (req.number),
    .cmd      (cmd),
    .stat     (stat),
    .is_prime (rsp.is_prime)
  );

  // block is busy right after taking a number
  `TDPT_ASSERT_NXT(a_busy_after_accept, clk, rst, req.valid && req.ready, !req.ready)

  // division only starts when the bound check has not already decided
  `TDPT_ASSERT_IMP(a_div_needed, clk, rst, cmd.start_div, !stat.trivial && !stat.sq_gt_n)

  // a pending result is never overwritten
  `TDPT_ASSERT_IMP(a_no_overwrite, clk, rst, cmd.post, !rsp.valid || rsp.ready)

endmodule

FILE: design/tdpt_datapath.sv
// ----------------------------------------------------------------------------
// Trial division datapath
// Number and divisor registers, running divisor square, bit-serial
// restoring remainder unit and the result register.
// ----------------------------------------------------------------------------
module tdpt_datapath
  import tdpt_pkg::*;
(
  input  logic                         clk,
  input  logic signed [DATA_WIDTH-1:0] number,
  input  cmd_t                         cmd,
  output stat_t                        stat,
  output logic                         is_prime
);

  logic [DATA_WIDTH-1:0] n;
  logic [DATA_WIDTH-1:0] d;
  logic [SQ_W-1:0]       sq;
  logic [DATA_WIDTH-1:0] rem;
  logic [DATA_WIDTH-1:0] shreg;
  logic [CNT_W-1:0]      cnt;
  logic                  verdict;

  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH:0]   diff;
  logic                  fits;

  // shift the next dividend bit into the partial remainder
  assign trial = {rem, shreg[DATA_WIDTH-1]};
  assign diff  = trial - {1'b0, d};
  assign fits  = trial >= {1'b0, d};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n  <= $unsigned(number);
      d  <= DATA_WIDTH'(FIRST_DIV);
      sq <= SQ_W'(FIRST_DIV * FIRST_DIV);
    end
    if (cmd.advance) begin
      // (d+1)^2 = d^2 + 2d + 1
      sq <= sq + SQ_W'({d, 1'b1});
      d  <= d + DATA_WIDTH'(1);
    end
    if (cmd.start_div) begin
      rem   <= '0;
      shreg <= n;
      cnt   <= '0;
    end
    if (cmd.div_step) begin
      rem   <= fits ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
      shreg <= shreg << 1;
      cnt   <= cnt + CNT_W'(1);
    end
    if (cmd.decide) begin
      verdict <= cmd.verdict;
    end
    if (cmd.post) begin
      is_prime <= verdict;
    end
  end

  assign stat.trivial  = n[DATA_WIDTH-1] || (n <= DATA_WIDTH'(1));
  assign stat.sq_gt_n  = sq > SQ_W'(n);
  assign stat.div_last = cnt == CNT_W'(DATA_WIDTH - 1);
  assign stat.rem_zero = rem == '0;

endmodule

FILE: design/tdpt_ctrl.sv
// ----------------------------------------------------------------------------
// Trial division controller
// Sequences load, bound check, serial division and result transfer.
// ----------------------------------------------------------------------------
module tdpt_ctrl
  import tdpt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_ready,
  output logic  rsp_valid,
  input  logic  rsp_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;
  logic   rsp_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.trivial) begin
          cmd.decide  = 1'b1;
          cmd.verdict = 1'b0;
          state_next  = S_POST;
        end else if (stat.sq_gt_n) begin
          cmd.decide  = 1'b1;
          cmd.verdict = 1'b1;
          state_next  = S_POST;
        end else begin
          cmd.start_div = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_TEST;
        end
      end
      S_TEST: begin
        if (stat.rem_zero) begin
          cmd.decide  = 1'b1;
          cmd.verdict = 1'b0;
          state_next  = S_POST;
        end else begin
          cmd.advance = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_POST: begin
        // output register free or draining this cycle
        if (!rsp_valid || rsp_ready) begin
          cmd.post   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.post) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

endmodule
